/* src/rv32e_pkg.sv */
// Package for the RV32I integer execute block: opcodes, status codes, shared types.
// No dependencies.
`default_nettype none
package rv32e_pkg;
  localparam logic [6:0] OpLoad  = 7'h03;
  localparam logic [6:0] OpImm   = 7'h13;
  localparam logic [6:0] OpStore = 7'h23;
  localparam logic [6:0] OpReg   = 7'h33;

  localparam logic [6:0] F7Zero = 7'h00;
  localparam logic [6:0] F7Alt  = 7'h20;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusStopped = 2'd1;
  localparam logic [1:0] StatusIgnored = 2'd2;

  localparam logic [0:0] CfgDataBase = 1'd0;
  localparam logic [0:0] CfgStartPc  = 1'd1;

  typedef enum logic [1:0] {
    KindAlu   = 2'd0,
    KindLoad  = 2'd1,
    KindStore = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  // Back end sequencing: instruction capture, execute, load data return.
  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StExec = 2'd1,
    StLoad = 2'd2
  } back_st_e;

  // Decoded instruction passed from the front end to the back end.
  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] pc;
    kind_e       kind;
    logic        bad;
    logic        stopped;
  } dec_t;
endpackage
`default_nettype wire

/* src/rv32e_if.sv */
// Valid/ready channel interface with a parameterized payload width.
// Depends on nothing.
`default_nettype none
interface rv32e_if #(parameter int W = 32) (input wire logic clk_i);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/rv32e_ram.sv */
// Generic single-write, one-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module rv32e_ram #(
  parameter int W = 8,
  parameter int D = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]              rdata_o
);
  logic [W-1:0] mem_q [D];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* src/rv32e_front.sv */
// Front end: accepts instructions, tracks PC and stop state, classifies, feeds queue.
// Depends on rv32e_pkg.
`default_nettype none
module rv32e_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [31:0]   instr_i,
  input  wire logic          pc_load_i,
  input  wire logic [31:0]   pc_value_i,
  output logic               q_valid_o,
  input  wire logic          q_ready_i,
  output rv32e_pkg::dec_t    q_data_o
);
  logic [31:0] pc_q, pc_d;
  logic stop_q, stop_d;
  // two-entry queue
  rv32e_pkg::dec_t ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic rd_q, wr_q;
  rv32e_pkg::dec_t dec;
  logic [6:0] op, f7;
  logic [2:0] f3;
  logic push, pop;

  assign op = instr_i[6:0];
  assign f3 = instr_i[14:12];
  assign f7 = instr_i[31:25];

  always_comb begin
    dec.instr = instr_i;
    dec.pc = pc_q;
    dec.stopped = stop_q;
    dec.bad = 1'b0;
    unique case (op)
      rv32e_pkg::OpReg: begin
        dec.kind = rv32e_pkg::KindAlu;
        dec.bad = (f7 != rv32e_pkg::F7Zero) &&
                  !((f7 == rv32e_pkg::F7Alt) && (f3 == 3'd0 || f3 == 3'd5));
      end
      rv32e_pkg::OpImm: begin
        dec.kind = rv32e_pkg::KindAlu;
        if (f3 == 3'd1) begin
          dec.bad = (f7 != rv32e_pkg::F7Zero);
        end else if (f3 == 3'd5) begin
          dec.bad = (f7 != rv32e_pkg::F7Zero) && (f7 != rv32e_pkg::F7Alt);
        end
      end
      rv32e_pkg::OpLoad: begin
        dec.kind = rv32e_pkg::KindLoad;
        dec.bad = (f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7);
      end
      rv32e_pkg::OpStore: begin
        dec.kind = rv32e_pkg::KindStore;
        dec.bad = (f3 > 3'd2);
      end
      default: dec.kind = rv32e_pkg::KindNone;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = ent_q[rd_q];

  always_comb begin
    pc_d = pc_q;
    stop_d = stop_q;
    if (pc_load_i) begin
      pc_d = pc_value_i;
    end else if (push && !stop_q) begin
      if (dec.bad) begin
        stop_d = 1'b1;
      end else begin
        pc_d = pc_q + 32'd4;
      end
    end
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 32'h0040_0000;
      stop_q <= 1'b0;
      cnt_q <= 2'd0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      stop_q <= stop_d;
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= dec;
    end
  end
endmodule
`default_nettype wire

/* src/rv32e_back.sv */
// Back end: register file reads, ALU, data memory access, write-back, output register.
// Depends on rv32e_pkg and rv32e_ram.
`default_nettype none
module rv32e_back #(
  parameter int DATA_BYTES = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [31:0]   base_i,
  input  wire logic          q_valid_i,
  output logic               q_ready_o,
  input  rv32e_pkg::dec_t    q_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [31:0]        exec_pc_o,
  output logic [4:0]         dest_index_o,
  output logic [31:0]        dest_value_o,
  output logic               dest_written_o,
  output logic               store_done_o,
  output logic [1:0]         status_o
);
  localparam int AW = $clog2(DATA_BYTES);
  localparam int LW = $clog2(DATA_BYTES / 4);
  localparam int NW = DATA_BYTES / 4;

  // Phase 0: capture the instruction (register file reads are combinational).
  // Phase 1: compute address / result, access memory.
  // Phase 2 (loads only): memory data arrives, write back.
  rv32e_pkg::back_st_e st_q, st_d;

  rv32e_pkg::dec_t cur_q;
  logic [31:0] rf_q [32];
  logic [31:0] a, b;
  logic [6:0] f7;
  logic [2:0] f3;
  logic [4:0] rd, r1, r2;
  logic [31:0] imm, simm, alu, addr, off;
  logic [31:0] sz;
  logic inwin;
  logic [31:0] res_d;
  logic wr_en, st_en;

  // word-interleaved byte lanes: lane k holds bytes with (addr-base)%4==k
  logic [AW-1:0] off_a;
  logic [1:0] sel_q;
  logic [LW-1:0] lane_addr [4];
  logic [7:0] lane_wd [4];
  logic [7:0] lane_rd [4];
  logic [3:0] lane_we;
  logic [2:0] f3_q;
  logic [4:0] rd_q2;
  logic inwin_q;

  // zero the data memory one row per cycle after reset
  logic clr_q;
  logic [LW-1:0] clr_row_q;

  logic out_busy;
  logic [31:0] ld_raw, ld_val;

  assign f3 = cur_q.instr[14:12];
  assign f7 = cur_q.instr[31:25];
  assign rd = cur_q.instr[11:7];
  assign r1 = cur_q.instr[19:15];
  assign r2 = cur_q.instr[24:20];
  assign a = rf_q[r1];
  assign b = rf_q[r2];
  assign imm = {{20{cur_q.instr[31]}}, cur_q.instr[31:20]};
  assign simm = {{20{cur_q.instr[31]}}, cur_q.instr[31:25], cur_q.instr[11:7]};

  always_comb begin
    logic [31:0] ob;
    logic [4:0] sh;
    ob = (cur_q.instr[6:0] == rv32e_pkg::OpReg) ? b : imm;
    sh = (cur_q.instr[6:0] == rv32e_pkg::OpReg) ? b[4:0] : r2;
    case (f3)
      3'd0: alu = (cur_q.instr[6:0] == rv32e_pkg::OpReg && f7 == rv32e_pkg::F7Alt) ?
                  a - ob : a + ob;
      3'd1: alu = a << sh;
      3'd2: alu = {31'd0, $signed(a) < $signed(ob)};
      3'd3: alu = {31'd0, a < ob};
      3'd4: alu = a ^ ob;
      3'd5: alu = (f7 == rv32e_pkg::F7Alt) ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6: alu = a | ob;
      default: alu = a & ob;
    endcase
  end

  assign addr = a + ((cur_q.kind == rv32e_pkg::KindStore) ? simm : imm);
  assign off = addr - base_i;
  always_comb begin
    case (f3[1:0])
      2'd0: sz = 32'd1;
      2'd1: sz = 32'd2;
      default: sz = 32'd4;
    endcase
  end
  assign inwin = (off <= 32'(DATA_BYTES) - sz);
  assign off_a = off[AW-1:0];

  assign out_busy = out_valid_o && !out_ready_i;
  assign q_ready_o = (st_q == rv32e_pkg::StIdle) && !clr_q;

  // each byte i of the access goes to lane (off+i)%4 at row (off+i)/4
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [1:0] idx;
      logic [AW-1:0] ba;
      idx = 2'(k) - off_a[1:0];
      ba = off_a + AW'(idx);
      lane_addr[k] = ba[AW-1:2];
      lane_wd[k] = b[8*idx +: 8];
      lane_we[k] = st_en && (32'(idx) < sz);
      if (clr_q) begin
        lane_addr[k] = clr_row_q;
        lane_wd[k] = 8'd0;
        lane_we[k] = 1'b1;
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    rv32e_ram #(.W(8), .D(NW)) u_ram (
      .clk_i(clk_i), .we_i(lane_we[k]), .waddr_i(lane_addr[k]), .wdata_i(lane_wd[k]),
      .raddr_i(lane_addr[k]), .rdata_o(lane_rd[k])
    );
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_raw[8*i +: 8] = lane_rd[2'(i) + sel_q];
    end
    case (f3_q)
      3'd0: ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
      3'd1: ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
      3'd4: ld_val = {24'd0, ld_raw[7:0]};
      3'd5: ld_val = {16'd0, ld_raw[15:0]};
      default: ld_val = ld_raw;
    endcase
    if (!inwin_q) ld_val = 32'd0;
  end

  logic exec_go, load_go;
  assign exec_go = (st_q == rv32e_pkg::StExec) && !out_busy;
  assign load_go = (st_q == rv32e_pkg::StLoad) && !out_busy;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      rv32e_pkg::StIdle: if (q_valid_i && q_ready_o) st_d = rv32e_pkg::StExec;
      rv32e_pkg::StExec: if (!out_busy) begin
        st_d = (cur_q.kind == rv32e_pkg::KindLoad && !cur_q.bad && !cur_q.stopped) ?
               rv32e_pkg::StLoad : rv32e_pkg::StIdle;
      end
      rv32e_pkg::StLoad: if (!out_busy) st_d = rv32e_pkg::StIdle;
      default: st_d = rv32e_pkg::StIdle;
    endcase
  end

  logic live;
  assign live = !cur_q.bad && !cur_q.stopped;
  assign st_en = exec_go && live && cur_q.kind == rv32e_pkg::KindStore && inwin;
  assign wr_en = exec_go && live && cur_q.kind == rv32e_pkg::KindAlu && rd != 5'd0;
  assign res_d = alu;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rv32e_pkg::StIdle;
      out_valid_o <= 1'b0;
      clr_q <= 1'b1;
      clr_row_q <= '0;
      for (int i = 0; i < 32; i++) rf_q[i] <= 32'd0;
    end else begin
      st_q <= st_d;
      if (clr_q) begin
        clr_row_q <= clr_row_q + 1'b1;
        if (clr_row_q == LW'(NW - 1)) clr_q <= 1'b0;
      end
      if ((exec_go && !(cur_q.kind == rv32e_pkg::KindLoad && live)) || load_go) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (wr_en) begin
        rf_q[rd] <= res_d;
      end else if (load_go && rd_q2 != 5'd0) begin
        rf_q[rd_q2] <= ld_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) cur_q <= q_data_i;
    if (exec_go) begin
      sel_q <= off_a[1:0];
      f3_q <= f3;
      rd_q2 <= rd;
      inwin_q <= inwin;
      exec_pc_o <= cur_q.pc;
      dest_index_o <= wr_en ? rd : 5'd0;
      dest_value_o <= wr_en ? res_d : 32'd0;
      dest_written_o <= wr_en;
      store_done_o <= st_en;
      if (!live) begin
        status_o <= rv32e_pkg::StatusStopped;
      end else if (cur_q.kind == rv32e_pkg::KindNone) begin
        status_o <= rv32e_pkg::StatusIgnored;
      end else begin
        status_o <= rv32e_pkg::StatusOk;
      end
    end else if (load_go) begin
      dest_index_o <= rd_q2;
      dest_value_o <= (rd_q2 != 5'd0) ? ld_val : 32'd0;
      dest_written_o <= (rd_q2 != 5'd0);
    end
  end
endmodule
`default_nettype wire

/* src/rv32i_alu_load_store_execute_top.sv */
// Top level of the RV32I integer execute block: front end, queue, back end.
// Depends on rv32e_pkg, rv32e_if, rv32e_front, rv32e_back.
//
// Usage:
//   in_if carries one 32-bit instruction word per transaction; out_if carries
//   one result transaction per instruction: {exec_pc, dest_index, dest_value,
//   dest_written, store_done, status}.
//   Configuration: cfg_we_i with cfg_idx_i 0 sets the data window base, 1 sets
//   the start PC and reloads the PC. Write only while the block is idle.
// Path: an accepted instruction is registered in the queue, then in the back
//   end's instruction register, then its result in the output registers;
//   loads first pass through the registered read of the data memory lanes.
// Sequencing: the back end takes a new instruction only once it is idle again,
//   after its capture then execute/memory sequence (plus load data for loads).
// Reset: the register file and data window base clear to zero, PC to 0x00400000;
//   then a clearing pass over all DATA_BYTES/4 rows (1024 at the default) zeroes
//   the data memory, and instructions wait in the queue until it ends.
// Stall: when out_if is not taken, the back end holds its result, the
//   two-entry queue fills and then in_if.ready drops.
`default_nettype none
module rv32i_alu_load_store_execute_top #(
  parameter int DATA_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  rv32e_if.sink            in_if,
  rv32e_if.source          out_if
);
  logic [31:0] base_q;
  logic q_valid, q_ready;
  rv32e_pkg::dec_t q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd0;
    end else if (cfg_we_i && cfg_idx_i == rv32e_pkg::CfgDataBase) begin
      base_q <= cfg_data_i;
    end
  end

  rv32e_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .instr_i(in_if.data),
    .pc_load_i(cfg_we_i && cfg_idx_i == rv32e_pkg::CfgStartPc),
    .pc_value_i(cfg_data_i),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  rv32e_back #(.DATA_BYTES(DATA_BYTES)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .base_i(base_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .exec_pc_o(out_if.data[72:41]), .dest_index_o(out_if.data[40:36]),
    .dest_value_o(out_if.data[35:4]), .dest_written_o(out_if.data[3]),
    .store_done_o(out_if.data[2]), .status_o(out_if.data[1:0])
  );
endmodule
`default_nettype wire

/* src/rv32e_checker.sv */
// Port-level checker for the execute block, bound to the top level.
// Depends on rv32e_pkg.
`default_nettype none
module rv32e_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [72:0] out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data[3] |-> out_data[40:36] != 5'd0) else $error("x0 written");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data[1:0] != 2'd3) else $error("bad status");
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data[1:0] == rv32e_pkg::StatusStopped |-> !out_data[3] && !out_data[2])
    else $error("stopped item has effect");
endmodule

bind rv32i_alu_load_store_execute_top rv32e_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_if.valid),
  .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire
